// ===== src/gbl_pkg.sv =====
// Package for the geographic bit-mask lookup block: field widths, codes,
// the queued command type and the effective-width helper.
// No dependencies; every other file but gbl_ram refers to it by scoped names.
`timescale 1ns / 1ps

package gbl_pkg;

	// Field widths
	localparam int LAT_W     = 32;
	localparam int LON_W     = 40;
	localparam int LROW_W    = 11;
	localparam int IDX_W     = 9;
	localparam int DATA_W    = 8;
	localparam int WIDTH_W   = 13;
	localparam int BPD_W     = 20;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;

	// Stream packing of the request word, lowest field first
	localparam int LAT_LSB   = 0;
	localparam int LON_LSB   = LAT_LSB + LAT_W;
	localparam int LROW_LSB  = LON_LSB + LON_W;
	localparam int IDX_LSB   = LROW_LSB + LROW_W;
	localparam int DATA_LSB  = IDX_LSB + IDX_W;
	localparam int S_FIELDS_W = DATA_LSB + DATA_W;
	localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((STATUS_W + 7) / 8) * 8;

	localparam int MAX_COLS_DEFAULT = 4096;

	// Arithmetic
	localparam int FRAC_SHIFT = 36;
	localparam int MUL_A_W    = LAT_W + 1;
	localparam int MUL_B_W    = BPD_W + 1;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int LON_SPLIT  = 20;
	localparam int LO_PROD_W  = LON_SPLIT + BPD_W;
	localparam int HI_PROD_W  = (LON_W - LON_SPLIT) + BPD_W;
	localparam int COL_SUM_W  = LON_W + BPD_W;
	localparam int FL_W       = COL_SUM_W - FRAC_SHIFT;
	localparam int ROW_W      = WIDTH_W - 1;
	localparam int ROWQ_W     = MUL_P_W - 1 - FRAC_SHIFT;
	localparam int MOD_BITS   = 4;
	localparam int MOD_STEPS  = FL_W / MOD_BITS;
	localparam int MOD_CNT_W  = $clog2(MOD_STEPS);
	localparam logic signed [MUL_A_W-1:0] LAT_NORTH = MUL_A_W'(90 * (1 << 20));

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_WIDTH      = 1'b0,
		REG_BITS_PER_DEGREE = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_CLEAR          = 3'd0,
		ST_SET            = 3'd1,
		ST_OUT_OF_RANGE   = 3'd2,
		ST_NOT_CONFIGURED = 3'd3,
		ST_LOAD_DONE      = 3'd4,
		ST_LOAD_BAD       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CMD_LOAD_OK,
		CMD_LOAD_BAD,
		CMD_NOT_CFG,
		CMD_QUERY
	} cmd_kind_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DECODE,
		B_MUL_ROW,
		B_CHK_ROW,
		B_MUL_HI,
		B_ACC,
		B_ABS,
		B_MOD,
		B_FIX,
		B_ADDR,
		B_READ,
		B_DONE
	} back_state_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic signed [LAT_W-1:0]   latitude;
		logic signed [LON_W-1:0]   longitude;
		logic [LROW_W-1:0]         load_row;
		logic [IDX_W-1:0]          load_byte_index;
		logic [DATA_W-1:0]         load_data;
	} cmd_t;

	// Configured width clamped to the store's column count
	function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] mw,
		input int max_cols);
		if (int'(mw) > max_cols)
			return WIDTH_W'(max_cols);
		return mw;
	endfunction

endpackage

// ===== src/gbl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gbl_front.sv =====
// Request front end: unpacks the stream word, checks load addresses and
// configuration, and pushes a classified command. Depends on gbl_pkg.
`timescale 1ns / 1ps

module gbl_front #(
	parameter int MAX_COLS = gbl_pkg::MAX_COLS_DEFAULT
) (
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gbl_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  logic [gbl_pkg::WIDTH_W-1:0]        mask_width,
	input  logic                               q_full,
	output logic                               q_push,
	output gbl_pkg::cmd_t                      q_cmd
);

	logic [gbl_pkg::WIDTH_W-1:0] w;
	logic                        row_bad;
	logic                        idx_bad;
	gbl_pkg::cmd_t               cmd;

	assign w = gbl_pkg::eff_width(mask_width, MAX_COLS);

	always_comb begin
		cmd.latitude        = $signed(s_tdata[gbl_pkg::LAT_LSB +: gbl_pkg::LAT_W]);
		cmd.longitude       = $signed(s_tdata[gbl_pkg::LON_LSB +: gbl_pkg::LON_W]);
		cmd.load_row        = s_tdata[gbl_pkg::LROW_LSB +: gbl_pkg::LROW_W];
		cmd.load_byte_index = s_tdata[gbl_pkg::IDX_LSB +: gbl_pkg::IDX_W];
		cmd.load_data       = s_tdata[gbl_pkg::DATA_LSB +: gbl_pkg::DATA_W];

		// Rows stop at half the width; bytes at the rounded-up width / 8
		row_bad = gbl_pkg::ROW_W'(cmd.load_row) >= gbl_pkg::ROW_W'(w >> 1);
		idx_bad = (gbl_pkg::WIDTH_W + 1)'(cmd.load_byte_index)
			>= (((gbl_pkg::WIDTH_W + 1)'(w) + (gbl_pkg::WIDTH_W + 1)'(7)) >> 3);

		if (gbl_pkg::opcode_t'(s_tuser) == gbl_pkg::OP_QUERY) begin
			cmd.kind = (w == '0) ? gbl_pkg::CMD_NOT_CFG : gbl_pkg::CMD_QUERY;
		end else begin
			cmd.kind = (row_bad || idx_bad) ? gbl_pkg::CMD_LOAD_BAD : gbl_pkg::CMD_LOAD_OK;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_cmd    = cmd;

endmodule

// ===== src/gbl_queue.sv =====
// Short command queue between front end and back end.
// Depends on gbl_pkg for the command type and depth.
`timescale 1ns / 1ps

module gbl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gbl_pkg::cmd_t push_cmd,
	input  logic          pop,
	output gbl_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (gbl_pkg::QUEUE_DEPTH > 1) ? $clog2(gbl_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(gbl_pkg::QUEUE_DEPTH + 1);

	gbl_pkg::cmd_t    slot_q [gbl_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(gbl_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gbl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gbl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== src/gbl_back.sv =====
// Back end: sequencer with one shared multiplier, a 4-bit-per-cycle
// remainder unit and the output register. Depends on gbl_pkg.
`timescale 1ns / 1ps

module gbl_back #(
	parameter int MAX_COLS = gbl_pkg::MAX_COLS_DEFAULT,
	parameter int ADDR_W   = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [gbl_pkg::WIDTH_W-1:0]       mask_width,
	input  logic [gbl_pkg::BPD_W-1:0]         bits_per_degree,
	input  gbl_pkg::cmd_t                     q_head,
	input  logic                              q_empty,
	output logic                              q_pop,
	output logic                              ram_we,
	output logic [ADDR_W-1:0]                 ram_waddr,
	output logic [gbl_pkg::DATA_W-1:0]        ram_wdata,
	output logic [ADDR_W-1:0]                 ram_raddr,
	input  logic [gbl_pkg::DATA_W-1:0]        ram_rdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gbl_pkg::STATUS_W-1:0]      m_status
);

	localparam int ROW_BYTES = (MAX_COLS + 7) / 8;
	localparam int WW        = gbl_pkg::WIDTH_W;

	gbl_pkg::back_state_t state_q, state_d;
	gbl_pkg::cmd_t        cmd_q;
	gbl_pkg::status_t     res_q;
	gbl_pkg::status_t     out_status_q;
	logic                 out_valid_q;

	logic [WW-1:0]                        w;
	logic signed [gbl_pkg::MUL_A_W-1:0]   mul_a;
	logic signed [gbl_pkg::MUL_B_W-1:0]   mul_b;
	logic signed [gbl_pkg::MUL_P_W-1:0]   mul_p;
	logic signed [gbl_pkg::MUL_P_W-1:0]   mul_q;
	logic [gbl_pkg::LO_PROD_W-1:0]        acc_q;
	logic [gbl_pkg::COL_SUM_W-1:0]        col_sum;
	logic [gbl_pkg::FL_W-1:0]             fl_q;
	logic [gbl_pkg::FL_W-1:0]             mag_q;
	logic                                 neg_q;
	logic [WW-1:0]                        rem_q;
	logic [WW-1:0]                        rem_d;
	logic [gbl_pkg::FL_W-1:0]             mag_d;
	logic [gbl_pkg::MOD_CNT_W-1:0]        cnt_q;
	logic [gbl_pkg::ROW_W-1:0]            row_q;
	logic [WW-1:0]                        col_q;
	logic                                 row_bad;
	logic                                 out_load;
	logic [31:0]                          waddr_full;
	logic [31:0]                          raddr_full;
	logic [2:0]                           bit_sel;

	assign w = gbl_pkg::eff_width(mask_width, MAX_COLS);

	// Shared multiplier, operand chosen by state
	always_comb begin
		case (state_q)
			gbl_pkg::B_MUL_ROW:
				mul_a = gbl_pkg::LAT_NORTH - $signed({cmd_q.latitude[gbl_pkg::LAT_W-1],
					cmd_q.latitude});
			gbl_pkg::B_CHK_ROW:
				mul_a = $signed({{(gbl_pkg::MUL_A_W - gbl_pkg::LON_SPLIT){1'b0}},
					cmd_q.longitude[gbl_pkg::LON_SPLIT-1:0]});
			gbl_pkg::B_MUL_HI:
				mul_a = $signed({{(gbl_pkg::MUL_A_W - gbl_pkg::LON_W + gbl_pkg::LON_SPLIT)
					{cmd_q.longitude[gbl_pkg::LON_W-1]}},
					cmd_q.longitude[gbl_pkg::LON_W-1:gbl_pkg::LON_SPLIT]});
			default:
				mul_a = '0;
		endcase
	end

	assign mul_b = $signed({1'b0, bits_per_degree});
	assign mul_p = mul_a * mul_b;

	// Row check on the registered product: negative or past the last row
	assign row_bad = mul_q[gbl_pkg::MUL_P_W-1]
		|| (mul_q[gbl_pkg::FRAC_SHIFT +: gbl_pkg::ROWQ_W] >= gbl_pkg::ROWQ_W'(w >> 1));

	// Recombine the two longitude partial products
	assign col_sum = {mul_q[gbl_pkg::HI_PROD_W-1:0], {gbl_pkg::LON_SPLIT{1'b0}}}
		+ gbl_pkg::COL_SUM_W'(acc_q);

	// Remainder unit: MOD_BITS restoring steps per cycle
	always_comb begin
		logic [WW:0]              t;
		logic [WW-1:0]            r;
		logic [gbl_pkg::FL_W-1:0] m;
		r = rem_q;
		m = mag_q;
		t = '0;
		for (int i = 0; i < gbl_pkg::MOD_BITS; i++) begin
			t = {r, m[gbl_pkg::FL_W-1]};
			m = m << 1;
			if (t >= {1'b0, w})
				t = t - {1'b0, w};
			r = t[WW-1:0];
		end
		rem_d = r;
		mag_d = m;
	end

	assign waddr_full = 32'(cmd_q.load_row) * 32'(ROW_BYTES) + 32'(cmd_q.load_byte_index);
	assign raddr_full = 32'(row_q) * 32'(ROW_BYTES) + 32'(col_q >> 3);
	assign ram_waddr  = waddr_full[ADDR_W-1:0];
	assign ram_raddr  = raddr_full[ADDR_W-1:0];
	assign ram_wdata  = cmd_q.load_data;
	assign bit_sel    = 3'(gbl_pkg::DATA_W - 1) - col_q[2:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbl_pkg::B_IDLE:
				if (!q_empty)
					state_d = gbl_pkg::B_DECODE;
			gbl_pkg::B_DECODE:
				state_d = (cmd_q.kind == gbl_pkg::CMD_QUERY) ? gbl_pkg::B_MUL_ROW
					: gbl_pkg::B_DONE;
			gbl_pkg::B_MUL_ROW:
				state_d = gbl_pkg::B_CHK_ROW;
			gbl_pkg::B_CHK_ROW:
				state_d = row_bad ? gbl_pkg::B_DONE : gbl_pkg::B_MUL_HI;
			gbl_pkg::B_MUL_HI:
				state_d = gbl_pkg::B_ACC;
			gbl_pkg::B_ACC:
				state_d = gbl_pkg::B_ABS;
			gbl_pkg::B_ABS:
				state_d = gbl_pkg::B_MOD;
			gbl_pkg::B_MOD:
				if (cnt_q == gbl_pkg::MOD_CNT_W'(gbl_pkg::MOD_STEPS - 1))
					state_d = gbl_pkg::B_FIX;
			gbl_pkg::B_FIX:
				state_d = gbl_pkg::B_ADDR;
			gbl_pkg::B_ADDR:
				state_d = gbl_pkg::B_READ;
			gbl_pkg::B_READ:
				state_d = gbl_pkg::B_DONE;
			gbl_pkg::B_DONE:
				if (out_load)
					state_d = gbl_pkg::B_IDLE;
			default:
				state_d = gbl_pkg::B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			gbl_pkg::B_IDLE:
				q_pop = !q_empty;
			gbl_pkg::B_DECODE:
				ram_we = cmd_q.kind == gbl_pkg::CMD_LOAD_OK;
			gbl_pkg::B_DONE:
				out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbl_pkg::B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (state_q == gbl_pkg::B_ABS)
				cnt_q <= '0;
			else if (state_q == gbl_pkg::B_MOD)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (q_pop)
			cmd_q <= q_head;
		if (out_load)
			out_status_q <= res_q;
		case (state_q)
			gbl_pkg::B_DECODE:
				case (cmd_q.kind)
					gbl_pkg::CMD_LOAD_OK:  res_q <= gbl_pkg::ST_LOAD_DONE;
					gbl_pkg::CMD_LOAD_BAD: res_q <= gbl_pkg::ST_LOAD_BAD;
					gbl_pkg::CMD_NOT_CFG:  res_q <= gbl_pkg::ST_NOT_CONFIGURED;
					default:               res_q <= gbl_pkg::ST_CLEAR;
				endcase
			gbl_pkg::B_CHK_ROW: begin
				row_q <= mul_q[gbl_pkg::FRAC_SHIFT +: gbl_pkg::ROW_W];
				if (row_bad)
					res_q <= gbl_pkg::ST_OUT_OF_RANGE;
			end
			gbl_pkg::B_MUL_HI:
				acc_q <= mul_q[gbl_pkg::LO_PROD_W-1:0];
			gbl_pkg::B_ACC:
				fl_q <= col_sum[gbl_pkg::COL_SUM_W-1:gbl_pkg::FRAC_SHIFT];
			gbl_pkg::B_ABS: begin
				// Floor towards minus infinity, then fold by magnitude
				neg_q <= fl_q[gbl_pkg::FL_W-1];
				mag_q <= fl_q[gbl_pkg::FL_W-1] ? (~fl_q + 1'b1) : fl_q;
				rem_q <= '0;
			end
			gbl_pkg::B_MOD: begin
				rem_q <= rem_d;
				mag_q <= mag_d;
			end
			gbl_pkg::B_FIX:
				col_q <= (neg_q && rem_q != '0) ? w - rem_q : rem_q;
			gbl_pkg::B_READ:
				res_q <= ram_rdata[bit_sel] ? gbl_pkg::ST_SET : gbl_pkg::ST_CLEAR;
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_status = out_status_q;

`ifndef SYNTH
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbl_pkg::B_FIX |-> rem_q < w)
		else $error("remainder not below width");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbl_pkg::B_ADDR |-> col_q < w)
		else $error("column not below width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbl_pkg::B_ADDR |-> WW'(row_q) < (w >> 1))
		else $error("row not below height");

	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbl_pkg::B_MOD
			&& cnt_q == gbl_pkg::MOD_CNT_W'(gbl_pkg::MOD_STEPS - 1))
		|=> state_q == gbl_pkg::B_FIX)
		else $error("remainder loop did not finish");

	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbl_pkg::B_READ |-> $past(state_q) == gbl_pkg::B_ADDR)
		else $error("mask byte sampled without address cycle");
`endif

endmodule

// ===== src/geo_bitmask_lookup_top.sv =====
// Top level of the geographic bit-mask lookup block: configuration registers,
// front end, command queue, back end and mask byte store.
// Depends on gbl_pkg, gbl_front, gbl_queue, gbl_back and gbl_ram.
`timescale 1ns / 1ps

// Usage
//   Requests enter on the s_ group; tuser is the opcode (0 load, 1 query).
//   A load writes one mask byte at (load_row, load_byte_index); a query looks
//   up the mask bit under a latitude/longitude in signed Q.20 degrees.
//   Every request gives exactly one status on the m_ group, in request order.
//   Configuration (mask_width at index 0, bits_per_degree at index 1) is
//   written through cfg_we/cfg_index/cfg_wdata; the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Sequencing
//   The back end pops a load, decodes and writes it, then loads its status
//   into the output register. A query uses the shared 33 x 21 multiplier
//   for three products and the column remainder unit, which retires 4 bits
//   a cycle over 24 bits. A query outside the rows skips the column steps;
//   one made while the block is not configured ends like a load.
// Reset and stalls
//   arst_n clears the registers and empties the queue; the mask store is not
//   cleared and must be loaded before it is queried. When the receiver holds
//   m_tready low the status waits in the output register, the back end parks
//   and the two-entry queue keeps taking requests until it fills.
module geo_bitmask_lookup_top #(
	parameter int MAX_COLS = gbl_pkg::MAX_COLS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// latitude, longitude, load_row, load_byte_index, load_data, zero pad
	input  logic [gbl_pkg::S_TDATA_W-1:0]      s_tdata,
	// opcode
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status, zero pad
	output logic [gbl_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int ROW_BYTES   = (MAX_COLS + 7) / 8;
	localparam int MAX_ROWS    = MAX_COLS / 2;
	localparam int STORE_BYTES = MAX_ROWS * ROW_BYTES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	logic [gbl_pkg::WIDTH_W-1:0]  mask_width_q;
	logic [gbl_pkg::BPD_W-1:0]    bits_per_degree_q;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_push;
	logic                         q_pop;
	gbl_pkg::cmd_t                q_cmd;
	gbl_pkg::cmd_t                q_head;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [gbl_pkg::DATA_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [gbl_pkg::DATA_W-1:0]   ram_rdata;
	logic [gbl_pkg::STATUS_W-1:0] status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q      <= '0;
			bits_per_degree_q <= '0;
		end else if (cfg_we) begin
			case (gbl_pkg::cfg_reg_t'(cfg_index))
				gbl_pkg::REG_MASK_WIDTH:
					mask_width_q <= cfg_wdata[gbl_pkg::WIDTH_W-1:0];
				gbl_pkg::REG_BITS_PER_DEGREE:
					bits_per_degree_q <= cfg_wdata[gbl_pkg::BPD_W-1:0];
				default: ;
			endcase
		end
	end

	gbl_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.mask_width (mask_width_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	gbl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	gbl_back #(
		.MAX_COLS (MAX_COLS),
		.ADDR_W   (ADDR_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.mask_width      (mask_width_q),
		.bits_per_degree (bits_per_degree_q),
		.q_head          (q_head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_status        (status)
	);

	gbl_ram #(
		.WIDTH (gbl_pkg::DATA_W),
		.DEPTH (STORE_BYTES)
	) u_mask_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tdata = gbl_pkg::M_TDATA_W'(status);

endmodule
